// ===== hw/rtl/mpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpr_pkg
// Shared types and constants of the max path row unit.
// ----------------------------------------------------------------------------
package mpr_pkg;

	localparam int CELL_W      = 16;
	localparam int PATH_W      = 32;
	localparam int ROW_WIDTH_W = 7;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [PATH_W-1:0]      PATH_MAX        = {PATH_W{1'b1}};
	localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 7'd64;

	// register index, taken from paddr[2]
	localparam logic REG_ROW_WIDTH = 1'b0;

	typedef struct packed {
		logic [CELL_W-1:0] cell_value;
		logic              start_grid;
	} in_item_t;

	typedef struct packed {
		logic [PATH_W-1:0] path_value;
		logic              row_end;
	} out_item_t;

	// per-cell control from the column sequencer
	typedef struct packed {
		logic last;
		logic first_row;
		logic edge_col;
	} seq_flags_t;

endpackage

// ===== hw/rtl/mpr_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpr_stream_if
// Valid/ready stream channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface mpr_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/max_path_row_dp_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_path_row_dp_unit
// Streams grid cells in row-major order and returns the best falling-path
// sum ending at each cell.
//
// cell_in carries cell_value and start_grid; start_grid marks the first
// cell of a new grid. path_out carries path_value and row_end, one result
// per request, in order. The APB port holds row_width at address 0.
// Each result passes the read-data stage and then the output register on its way to path_out.
// Throughput is one cell per cycle while path_out does not stall: each cell does one read of the row
// store (two ports) and one write-back, with the write forwarded to the
// next cell when both land on the same edge.
// Reset clears the column state, sets the first-row flag and sets
// row_width to 64; the row store is not cleared and needs no sweep.
// When path_out stalls, one result waits in the output register and one
// more cell waits in the read-data stage; cell_in then drops ready.
// ----------------------------------------------------------------------------
module max_path_row_dp_unit
	import mpr_pkg::*;
#(
	parameter int MAX_COLUMNS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	mpr_stream_if.sink          cell_in,
	mpr_stream_if.source        path_out,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	localparam int AW = $clog2(MAX_COLUMNS);

	logic [ROW_WIDTH_W-1:0] row_width;
	logic                   accept;
	logic                   in_ready;
	in_item_t               in_item;
	out_item_t              out_item;
	logic                   out_valid;
	logic [AW-1:0]          col;
	logic [AW-1:0]          col_right;
	seq_flags_t             flags;
	logic [PATH_W-1:0]      rd_above;
	logic [PATH_W-1:0]      rd_right;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [PATH_W-1:0]      wr_data;

	assign in_item       = cell_in.data;
	assign cell_in.ready = in_ready;
	assign accept        = cell_in.valid && in_ready;

	assign path_out.valid = out_valid;
	assign path_out.data  = out_item;

	mpr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.row_width (row_width)
	);

	mpr_col_seq #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.AW          (AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.start_grid (in_item.start_grid),
		.row_width  (row_width),
		.col        (col),
		.col_right  (col_right),
		.flags      (flags)
	);

	mpr_row_mem #(
		.DEPTH (MAX_COLUMNS),
		.AW    (AW)
	) u_mem (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr_a (col),
		.rd_addr_b (col_right),
		.rd_data_a (rd_above),
		.rd_data_b (rd_right),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	mpr_cell_calc #(
		.AW (AW)
	) u_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cell_value (in_item.cell_value),
		.flags      (flags),
		.col        (col),
		.col_right  (col_right),
		.rd_above   (rd_above),
		.rd_right   (rd_right),
		.in_ready   (in_ready),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.out_valid  (out_valid),
		.out_ready  (path_out.ready),
		.out_item   (out_item)
	);

`ifndef ASSERT_OFF
	// every write-back also loads a result
	a_write_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> path_out.valid)
		else $error("row store written without a result");

	// input stalls only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cell_in.ready |-> (path_out.valid && !path_out.ready))
		else $error("input stalled while output free");

	// the last column sends the sequencer back to column zero
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && flags.last) |=> (u_seq.column_index_q == '0))
		else $error("column did not wrap at row end");

	// right-neighbor address never leaves the row store
	a_right_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ((32)'(col_right) < (32)'(MAX_COLUMNS)))
		else $error("right neighbor address out of range");
`endif

endmodule

// ===== hw/rtl/mpr_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpr_cfg_regs
// APB-style register port holding the row width.
// ----------------------------------------------------------------------------
module mpr_cfg_regs
	import mpr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [PDATA_W-1:0]     pwdata,
	output logic [PDATA_W-1:0]     prdata,
	output logic                   pready,
	output logic [ROW_WIDTH_W-1:0] row_width
);

	logic [ROW_WIDTH_W-1:0] row_width_q;
	logic                   reg_idx;
	logic                   wr_hit;

	assign reg_idx = paddr[2];
	assign wr_hit  = psel && penable && pwrite && (reg_idx == REG_ROW_WIDTH);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RESET;
		end else if (wr_hit) begin
			row_width_q <= pwdata[ROW_WIDTH_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_ROW_WIDTH) begin
			prdata = PDATA_W'(row_width_q);
		end
	end

	assign row_width = row_width_q;

endmodule

// ===== hw/rtl/mpr_row_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpr_row_mem
// Previous-row result store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mpr_row_mem
	import mpr_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr_a,
	input  logic [AW-1:0]     rd_addr_b,
	output logic [PATH_W-1:0] rd_data_a,
	output logic [PATH_W-1:0] rd_data_b,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [PATH_W-1:0] wr_data
);

	logic [PATH_W-1:0] mem [DEPTH];
	logic [PATH_W-1:0] rd_data_a_q;
	logic [PATH_W-1:0] rd_data_b_q;

	// read during write returns the old entry; the pipeline forwards around it
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a_q <= mem[rd_addr_a];
			rd_data_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_data_a = rd_data_a_q;
	assign rd_data_b = rd_data_b_q;

endmodule

// ===== hw/rtl/mpr_col_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpr_col_seq
// Column sequencer: tracks column and first-row state, forms read addresses.
// ----------------------------------------------------------------------------
module mpr_col_seq
	import mpr_pkg::*;
#(
	parameter int MAX_COLUMNS = 64,
	parameter int AW          = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic                   start_grid,
	input  logic [ROW_WIDTH_W-1:0] row_width,
	output logic [AW-1:0]          col,
	output logic [AW-1:0]          col_right,
	output seq_flags_t             flags
);

	localparam int WUW = ($clog2(MAX_COLUMNS + 1) > ROW_WIDTH_W) ?
		$clog2(MAX_COLUMNS + 1) : ROW_WIDTH_W;
	localparam logic [WUW-1:0] WMAX = WUW'(MAX_COLUMNS);
	localparam logic [WUW-1:0] WMIN = WUW'(2);

	logic [AW-1:0]  column_index_q;
	logic           in_first_row_q;
	logic [WUW-1:0] rw_ext;
	logic [WUW-1:0] w_eff;
	logic [WUW-1:0] w_last;
	logic [AW-1:0]  col_raw;
	logic           last;

	assign rw_ext = WUW'(row_width);

	always_comb begin
		if (rw_ext < WMIN) begin
			w_eff = WMIN;
		end else if (rw_ext > WMAX) begin
			w_eff = WMAX;
		end else begin
			w_eff = rw_ext;
		end
	end

	assign w_last  = w_eff - WUW'(1);
	assign col_raw = start_grid ? '0 : column_index_q;

	// a column past a shrunk width is taken as the right edge
	always_comb begin
		if (WUW'(col_raw) >= w_eff) begin
			col = w_last[AW-1:0];
		end else begin
			col = col_raw;
		end
	end

	assign last      = (WUW'(col) == w_last);
	assign col_right = last ? col : col + AW'(1);

	assign flags.last      = last;
	assign flags.first_row = start_grid || in_first_row_q;
	assign flags.edge_col  = (col == '0) || last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_index_q <= '0;
			in_first_row_q <= 1'b1;
		end else if (accept) begin
			if (last) begin
				column_index_q <= '0;
				in_first_row_q <= 1'b0;
			end else begin
				column_index_q <= col + AW'(1);
				in_first_row_q <= flags.first_row;
			end
		end
	end

endmodule

// ===== hw/rtl/mpr_cell_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpr_cell_calc
// Read-data stage: picks the best parent, adds the cell, writes back and
// fills the result register.
// ----------------------------------------------------------------------------
module mpr_cell_calc
	import mpr_pkg::*;
#(
	parameter int AW = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [CELL_W-1:0] cell_value,
	input  seq_flags_t        flags,
	input  logic [AW-1:0]     col,
	input  logic [AW-1:0]     col_right,
	input  logic [PATH_W-1:0] rd_above,
	input  logic [PATH_W-1:0] rd_right,
	output logic              in_ready,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output logic [PATH_W-1:0] wr_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_item
);

	logic              s1_valid_q;
	logic [CELL_W-1:0] cell_s1;
	seq_flags_t        flags_s1;
	logic [AW-1:0]     col_s1;
	logic              hit_above_s1;
	logic              hit_right_s1;
	logic [PATH_W-1:0] fwd_s1;
	logic [PATH_W-1:0] left_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              advance;
	logic [PATH_W-1:0] above;
	logic [PATH_W-1:0] right;
	logic [PATH_W-1:0] best;
	logic [PATH_W:0]   sum;
	logic [PATH_W-1:0] result;

	assign advance  = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || advance;

	// the entry written by the leaving cell is read stale at the same edge
	assign above = hit_above_s1 ? fwd_s1 : rd_above;
	assign right = hit_right_s1 ? fwd_s1 : rd_right;

	always_comb begin
		best = (left_q > above) ? left_q : above;
		if (right > best) begin
			best = right;
		end
		if (flags_s1.edge_col) begin
			best = above;
		end
		sum = {1'b0, best} + (PATH_W + 1)'(cell_s1);
		if (flags_s1.first_row) begin
			result = PATH_W'(cell_s1);
		end else if (sum[PATH_W]) begin
			result = PATH_MAX;
		end else begin
			result = sum[PATH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			left_q      <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				left_q      <= above;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1      <= cell_value;
			flags_s1     <= flags;
			col_s1       <= col;
			hit_above_s1 <= advance && (col_s1 == col);
			hit_right_s1 <= advance && (col_s1 == col_right);
			fwd_s1       <= result;
		end
		if (advance) begin
			out_q.path_value <= result;
			out_q.row_end    <= flags_s1.last;
		end
	end

	assign wr_en     = advance;
	assign wr_addr   = col_s1;
	assign wr_data   = result;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== sim/tb_max_path_row_dp_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_path_row_dp_unit
// Streams grids of cells through max_path_row_dp_unit under random idling
// and back-pressure, and changes row_width over APB while the unit is idle.
// A tracker follows the row DP on its own copy of the previous row, predicts
// every path_value and row_end, and matches each result in order.
// ----------------------------------------------------------------------------
module tb_max_path_row_dp_unit;
	import mpr_pkg::*;

	localparam int MAX_COLS = 64;
	localparam logic [PADDR_W-1:0] ROW_WIDTH_ADDR = {REG_ROW_WIDTH, 2'b00};
	localparam logic [PADDR_W-1:0] SPARE_ADDR     = {~REG_ROW_WIDTH, 2'b00};
	localparam logic [CELL_W-1:0]  CELL_MAX       = {CELL_W{1'b1}};

	class falling_path_tracker;
		logic [PATH_W-1:0]      row_sums [MAX_COLS];
		logic [PATH_W-1:0]      diag_hold;
		logic [ROW_WIDTH_W-1:0] width_reg;
		int unsigned            col_idx;
		int unsigned            filled;
		bit                     first_row;
		out_item_t              owed_paths [$];
		int unsigned            bad_paths;

		function new();
			foreach (row_sums[i]) row_sums[i] = '0;
			diag_hold = '0;
			width_reg = ROW_WIDTH_RESET;
			col_idx   = 0;
			filled    = 0;
			first_row = 1'b1;
			bad_paths = 0;
		endfunction

		function int unsigned width_used();
			if (width_reg < 2) return 2;
			if (width_reg > MAX_COLS) return MAX_COLS;
			return 32'(width_reg);
		endfunction

		// a later row would read columns the store never held
		function bit needs_restart();
			return !first_row && width_used() > filled;
		endfunction

		function void take_cell(in_item_t c);
			int unsigned       w;
			int unsigned       col;
			bit                last;
			logic [PATH_W-1:0] above;
			logic [PATH_W-1:0] base;
			logic [PATH_W:0]   wide;
			out_item_t         r;
			w = width_used();
			if (c.start_grid) begin
				col_idx   = 0;
				first_row = 1'b1;
				diag_hold = '0;
			end
			col   = (col_idx >= w) ? w - 1 : col_idx;
			last  = (col == w - 1);
			above = row_sums[col];
			if (first_row) begin
				r.path_value = {{(PATH_W-CELL_W){1'b0}}, c.cell_value};
			end else begin
				base = above;
				if (col != 0 && !last) begin
					if (diag_hold > base) base = diag_hold;
					if (row_sums[col+1] > base) base = row_sums[col+1];
				end
				wide = {1'b0, base} + {{(PATH_W+1-CELL_W){1'b0}}, c.cell_value};
				r.path_value = wide[PATH_W] ? PATH_MAX : wide[PATH_W-1:0];
			end
			r.row_end     = last;
			diag_hold     = above;
			row_sums[col] = r.path_value;
			if (col + 1 > filled) filled = col + 1;
			if (last) begin
				col_idx   = 0;
				first_row = 1'b0;
			end else begin
				col_idx = col + 1;
			end
			owed_paths.push_back(r);
		endfunction

		function void match_path(out_item_t got);
			out_item_t want;
			if (owed_paths.size() == 0) begin
				bad_paths++;
				if (bad_paths <= 10)
					$display("path with none owed: got %h row_end %0b",
						got.path_value, got.row_end);
			end else begin
				want = owed_paths.pop_front();
				if (got.path_value !== want.path_value || got.row_end !== want.row_end) begin
					bad_paths++;
					if (bad_paths <= 10)
						$display("path mismatch: want %h row_end %0b, got %h row_end %0b",
							want.path_value, want.row_end, got.path_value, got.row_end);
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	int unsigned cells_sent = 0;
	bit          stall_req = 1'b0;
	bit          stall_served = 1'b0;

	falling_path_tracker tracker = new();

	mpr_stream_if #(.T(in_item_t))  cell_ch ();
	mpr_stream_if #(.T(out_item_t)) path_ch ();

	max_path_row_dp_unit #(
		.MAX_COLUMNS(MAX_COLS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cell_in (cell_ch),
		.path_out(path_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	task automatic send_cell(input in_item_t c);
		if ($urandom_range(99) < send_idle) begin
			cell_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		cell_ch.valid <= 1'b1;
		cell_ch.data  <= c;
		do @(posedge clk); while (!cell_ch.ready);
		tracker.take_cell(c);
		cells_sent++;
	endtask

	task automatic send_pair(input logic [CELL_W-1:0] v, input logic s);
		in_item_t c;
		c.cell_value = v;
		c.start_grid = s;
		send_cell(c);
	endtask

	// drop valid and wait until every owed path has come back
	task automatic drain_results();
		cell_ch.valid <= 1'b0;
		while (tracker.owed_paths.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] word);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ROW_WIDTH_ADDR) tracker.width_reg = word[ROW_WIDTH_W-1:0];
	endtask

	task automatic set_row_width(input logic [ROW_WIDTH_W-1:0] w);
		logic [PDATA_W-1:0] word;
		word = $urandom();
		word[ROW_WIDTH_W-1:0] = w;
		apb_write(ROW_WIDTH_ADDR, word);
	endtask

	function automatic logic [ROW_WIDTH_W-1:0] pick_width();
		case ($urandom_range(11))
			0:       return ROW_WIDTH_W'($urandom_range(1));
			1:       return ROW_WIDTH_W'($urandom_range(MAX_COLS + 1, 127));
			2:       return ROW_WIDTH_W'(MAX_COLS);
			3:       return ROW_WIDTH_W'($urandom_range(9, MAX_COLS - 1));
			default: return ROW_WIDTH_W'($urandom_range(2, 8));
		endcase
	endfunction

	task automatic run_grids(input int unsigned n_cells);
		int unsigned goal;
		int unsigned w;
		int unsigned total;
		int unsigned cut;
		in_item_t    c;
		goal = cells_sent + n_cells;
		while (cells_sent < goal) begin
			if ($urandom_range(2) == 0) begin
				drain_results();
				set_row_width(pick_width());
			end
			w = tracker.width_used();
			total = w * ((w > 16) ? $urandom_range(1, 2) : $urandom_range(1, 6));
			// cut some grids short
			if ($urandom_range(5) == 0) total = $urandom_range(1, total);
			cut = (total > 1 && $urandom_range(7) == 0) ? $urandom_range(1, total - 1) : 0;
			for (int unsigned k = 0; k < total; k++) begin
				if (cut != 0 && k == cut) begin
					drain_results();
					set_row_width(pick_width());
				end
				case ($urandom_range(7))
					0:       c.cell_value = CELL_MAX;
					1:       c.cell_value = '0;
					2:       c.cell_value = CELL_W'($urandom_range(15));
					default: c.cell_value = CELL_W'($urandom());
				endcase
				c.start_grid = (k == 0) || ($urandom_range(149) == 0) || tracker.needs_restart();
				send_cell(c);
			end
		end
	endtask

	initial begin : path_sink
		int unsigned hold_left;
		hold_left = 0;
		path_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (path_ch.valid && path_ch.ready) tracker.match_path(path_ch.data);
			if (stall_req && !stall_served) begin
				hold_left    = 400;
				stall_served = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				path_ch.ready <= 1'b0;
			end else begin
				path_ch.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	initial begin
		arst_n        <= 1'b0;
		cell_ch.valid <= 1'b0;
		cell_ch.data  <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 23;
		recv_idle = 81;

		// reset width, then shrink mid-row so the next cell closes the row
		send_pair(CELL_MAX, 1'b1);
		send_pair('0, 1'b0);
		send_pair(16'h8000, 1'b0);
		drain_results();
		set_row_width(7'd2);
		send_pair(16'h1234, 1'b0);
		send_pair(CELL_MAX, 1'b0);
		send_pair(CELL_MAX, 1'b0);
		// widths below range act as two
		drain_results();
		set_row_width(7'd1);
		send_pair(16'h5555, 1'b0);
		send_pair(16'hAAAA, 1'b0);
		drain_results();
		set_row_width(7'd0);
		apb_write(SPARE_ADDR, 32'h0000_0007);
		send_pair(16'h00FF, 1'b0);
		send_pair(16'hFF00, 1'b0);
		// interior column takes the best of three
		drain_results();
		set_row_width(7'd3);
		send_pair(CELL_MAX, 1'b0);
		send_pair(16'h0001, 1'b0);
		send_pair(16'h7FFF, 1'b0);
		send_pair(16'h0010, 1'b0);
		send_pair('0, 1'b0);
		send_pair(CELL_MAX, 1'b0);
		// new grid in the middle of a row
		send_pair(16'h0005, 1'b0);
		send_pair(16'h0007, 1'b1);
		send_pair(16'h0009, 1'b0);
		send_pair(16'h000B, 1'b0);
		send_pair(16'h0003, 1'b0);
		send_pair(16'h0002, 1'b0);
		send_pair(16'h0001, 1'b0);

		run_grids(600);
		send_idle = 81;
		recv_idle = 23;
		run_grids(600);
		send_idle = 0;
		recv_idle = 0;
		stall_req = 1'b1;
		run_grids(600);

		drain_results();
		if (tracker.bad_paths == 0) begin
			$display("PASS max_path_row_dp_unit");
		end else begin
			$display("FAIL max_path_row_dp_unit");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAIL max_path_row_dp_unit");
		$finish;
	end

endmodule
